### rtl/npc_pkg.sv
// ---------------------------------------------------------------------------
// npc_pkg: shared types, constants and functions for the nearest palette
// color search unit.
// ---------------------------------------------------------------------------
package npc_pkg;

  // Largest number of color targets the table supports
  localparam int unsigned MAX_TARGETS = 16;

  // Entries with an index at or above this are not compared
  localparam int unsigned PALETTE_SIZE = 256;

  // Distance value of a target that has not matched any entry yet
  localparam logic [7:0] NO_MATCH_DIST = 8'hFF;

  // Stream payload widths
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 24;

  // Standard 16 text-mode colors in 6-bit DAC units
  localparam logic [5:0] TARGET_R [MAX_TARGETS] = '{
    6'd0,  6'd0,  6'd0,  6'd0,  6'd42, 6'd42, 6'd42, 6'd42,
    6'd21, 6'd21, 6'd21, 6'd21, 6'd63, 6'd63, 6'd63, 6'd63
  };
  localparam logic [5:0] TARGET_G [MAX_TARGETS] = '{
    6'd0,  6'd0,  6'd42, 6'd42, 6'd0,  6'd0,  6'd21, 6'd42,
    6'd21, 6'd21, 6'd63, 6'd63, 6'd21, 6'd21, 6'd63, 6'd63
  };
  localparam logic [5:0] TARGET_B [MAX_TARGETS] = '{
    6'd0,  6'd42, 6'd0,  6'd42, 6'd0,  6'd42, 6'd0,  6'd42,
    6'd21, 6'd63, 6'd21, 6'd63, 6'd21, 6'd63, 6'd21, 6'd63
  };

  // Best match kept for one target
  typedef struct packed {
    logic [7:0] index;
    logic [7:0] distance;
  } npc_match_t;

  // Absolute difference of two channel values
  function automatic logic [5:0] abs_diff(input logic [5:0] a, input logic [5:0] b);
    logic [5:0] res;
    begin
      res = (a > b) ? (a - b) : (b - a);
      return res;
    end
  endfunction

  // Manhattan distance from a color to one target, at most 189
  function automatic logic [7:0] target_distance(input logic [3:0] t,
                                                 input logic [5:0] r,
                                                 input logic [5:0] g,
                                                 input logic [5:0] b);
    logic [7:0] sum;
    begin
      sum = 8'(abs_diff(r, TARGET_R[t])) + 8'(abs_diff(g, TARGET_G[t]))
          + 8'(abs_diff(b, TARGET_B[t]));
      return sum;
    end
  endfunction

endpackage

### rtl/npc_min_track.sv
// ---------------------------------------------------------------------------
// npc_min_track: running minimum per target
// Compares one registered entry with every target in parallel, keeps
// the smallest distance and its entry index, and on the final entry hands
// the updated minima to the result sequencer and clears them.
// ---------------------------------------------------------------------------
module npc_min_track #(
  parameter int unsigned NUM_TARGETS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  input  logic [7:0]             entry_index,
  input  logic [5:0]             red,
  input  logic [5:0]             green,
  input  logic [5:0]             blue,
  input  logic                   final_entry,
  output logic                   snap_load,
  output npc_pkg::npc_match_t    snap [NUM_TARGETS]
);

  npc_pkg::npc_match_t minima      [NUM_TARGETS];
  npc_pkg::npc_match_t minima_next [NUM_TARGETS];
  logic                in_palette;
  logic [7:0]          target_dist [NUM_TARGETS];

  // Skip entries that lie beyond the palette
  assign in_palette = {1'b0, entry_index} < 9'(npc_pkg::PALETTE_SIZE);

  // Compare against every target; strictly smaller wins, so ties keep the earlier entry
  always_comb begin
    for (int t = 0; t < NUM_TARGETS; t++) begin
      target_dist[t] = npc_pkg::target_distance(4'(t), red, green, blue);
      minima_next[t] = minima[t];
      if (item_valid && in_palette && (target_dist[t] < minima[t].distance)) begin
        minima_next[t].distance = target_dist[t];
        minima_next[t].index    = entry_index;
      end
    end
  end

  // Hand over the updated minima on the final entry
  assign snap_load = item_valid && final_entry;
  assign snap      = minima_next;

  // Hold minima; clear after a run ends
  always_ff @(posedge clk) begin
    for (int t = 0; t < NUM_TARGETS; t++) begin
      if (rst || snap_load) begin
        minima[t].distance <= npc_pkg::NO_MATCH_DIST;
        minima[t].index    <= 8'd0;
      end else begin
        minima[t] <= minima_next[t];
      end
    end
  end

endmodule

### rtl/npc_emitter.sv
// ---------------------------------------------------------------------------
// npc_emitter: result bank and sequencer
// Captures the minima of a finished run and transfers one result per target
// in target order through an output register.
// ---------------------------------------------------------------------------
module npc_emitter #(
  parameter int unsigned NUM_TARGETS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   snap_load,
  input  npc_pkg::npc_match_t    snap [NUM_TARGETS],
  output logic                   busy,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [3:0]             target_number,
  output logic [7:0]             best_index,
  output logic [7:0]             best_distance,
  output logic                   run_end
);

  localparam int unsigned TGT_W = (NUM_TARGETS > 1) ? $clog2(NUM_TARGETS) : 1;
  localparam logic [TGT_W-1:0] LAST_TGT = TGT_W'(NUM_TARGETS - 1);

  npc_pkg::npc_match_t bank [NUM_TARGETS];
  logic [TGT_W-1:0]    cnt;
  logic                fire;

  // Move the next result when the output register is free
  assign fire = busy && (!out_valid || out_ready);

  // Capture a finished run
  always_ff @(posedge clk) begin
    if (snap_load) begin
      bank <= snap;
    end
  end

  // Step through the targets
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (snap_load) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (fire) begin
      if (cnt == LAST_TGT) begin
        busy <= 1'b0;
        cnt  <= '0;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      target_number <= 4'(cnt);
      best_index    <= bank[cnt].index;
      best_distance <= bank[cnt].distance;
      run_end       <= (cnt == LAST_TGT);
    end
  end

endmodule

### rtl/nearest_palette_color_search_unit.sv
// ---------------------------------------------------------------------------
// nearest_palette_color_search_unit: nearest standard color per target
// Streams 6-bit RGB palette entries and tracks, for each standard color,
// the entry with the smallest sum of absolute channel differences.
// ---------------------------------------------------------------------------
// Palette entries are taken one per cycle unless a final entry is held back
// (see below): each entry sits in an input register while all targets are
// compared against it in parallel and the running minima update. An entry
// marked tlast closes the run: its minima move into a result bank, the
// minima clear, and NUM_TARGETS results leave on the master side, one per
// cycle while tready is high, the last one with tlast. Entries of the next
// palette keep streaming in while those results go out; a second final
// entry waits in the input register until the bank has emptied, so a later
// final entry is taken only after the bank has been loaded and all
// NUM_TARGETS results have moved into the output register. The final entry
// loads the bank; the first result then moves into the output register.
// ---------------------------------------------------------------------------
module nearest_palette_color_search_unit #(
  parameter int unsigned NUM_TARGETS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  // entry_index[7:0], red[13:8], green[19:14], blue[25:20], zero[31:26]
  input  logic [npc_pkg::IN_DATA_W-1:0]   s_tdata,
  input  logic                            s_tlast,   // final_entry
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // target_number[3:0], best_index[11:4], best_distance[19:12], zero[23:20]
  output logic [npc_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic                            m_tlast,   // run_end
  output logic                            m_tvalid,
  input  logic                            m_tready
);

  logic                in_valid;
  logic [7:0]          in_index;
  logic [5:0]          in_red;
  logic [5:0]          in_green;
  logic [5:0]          in_blue;
  logic                in_final;
  logic                go;
  logic                busy;
  logic                snap_load;
  npc_pkg::npc_match_t snap [NUM_TARGETS];
  logic [3:0]          target_number;
  logic [7:0]          best_index;
  logic [7:0]          best_distance;

  // A final entry waits while the previous run is still being sent
  assign go       = in_valid && (!in_final || !busy);
  assign s_tready = !in_valid || go;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_index <= s_tdata[7:0];
      in_red   <= s_tdata[13:8];
      in_green <= s_tdata[19:14];
      in_blue  <= s_tdata[25:20];
      in_final <= s_tlast;
    end
  end

  npc_min_track #(
    .NUM_TARGETS (NUM_TARGETS)
  ) u_min_track (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (go),
    .entry_index (in_index),
    .red         (in_red),
    .green       (in_green),
    .blue        (in_blue),
    .final_entry (in_final),
    .snap_load   (snap_load),
    .snap        (snap)
  );

  npc_emitter #(
    .NUM_TARGETS (NUM_TARGETS)
  ) u_emitter (
    .clk           (clk),
    .rst           (rst),
    .snap_load     (snap_load),
    .snap          (snap),
    .busy          (busy),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .target_number (target_number),
    .best_index    (best_index),
    .best_distance (best_distance),
    .run_end       (m_tlast)
  );

  // Pack the result fields
  assign m_tdata = {4'd0, best_distance, best_index, target_number};

endmodule
